/* hdl/b64f_pkg.sv */
// ----------------------------------------------------------------------------
// b64f_pkg
// Types and constants shared by the formatted base64 encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package b64f_pkg;

  localparam int KEY_WORDS  = 8;
  localparam int KEY_W      = 64;
  localparam int KEY_SEL_W  = $clog2(KEY_WORDS);
  localparam int CFG_IDX_W  = 4;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 6;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_PAD     = 8'h3D;  // '='
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;  // ' '
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;  // '\n'

  // Number of trailing characters replaced by '='
  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_ONE  = 2'd1,
    PAD_TWO  = 2'd2
  } pad_t;

  // One group handed from the front to the back
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    pad_t       pad;
    logic       sp;
    logic       nl;
  } grp_cmd_t;

endpackage

`default_nettype wire

/* hdl/b64f_front.sv */
// ----------------------------------------------------------------------------
// b64f_front
// Collects input bytes into groups, tracks separator counters and queues
// one command per finished group.
// ----------------------------------------------------------------------------
`default_nettype none

module b64f_front #(
  parameter int GROUPS_PER_SPACE = 2,
  parameter int GROUPS_PER_LINE  = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_stream,
  input  wire logic               q_full,
  output logic                    enq,
  output b64f_pkg::grp_cmd_t      enq_cmd
);

  localparam int SPC_W = $clog2(GROUPS_PER_SPACE + 1);
  localparam int LNC_W = $clog2(GROUPS_PER_LINE + 1);

  logic [7:0]       pend [2];
  logic [1:0]       byte_count;
  logic [SPC_W-1:0] space_count;
  logic [LNC_W-1:0] line_count;

  logic accept;
  logic sp_due;
  logic nl_due;

  assign accept = push && !q_full;
  assign sp_due = space_count >= SPC_W'(GROUPS_PER_SPACE);
  assign nl_due = line_count >= LNC_W'(GROUPS_PER_LINE);

  always_comb begin
    enq         = 1'b0;
    enq_cmd.b0  = pend[0];
    enq_cmd.b1  = pend[1];
    enq_cmd.b2  = data_byte;
    enq_cmd.pad = b64f_pkg::PAD_NONE;
    enq_cmd.sp  = sp_due;
    enq_cmd.nl  = nl_due;
    if (accept) begin
      if (end_of_stream) begin
        enq        = byte_count != 2'd0;
        enq_cmd.b2 = 8'd0;
        if (byte_count == 2'd1) begin
          enq_cmd.b1  = 8'd0;
          enq_cmd.pad = b64f_pkg::PAD_TWO;
        end else begin
          enq_cmd.pad = b64f_pkg::PAD_ONE;
        end
      end else begin
        enq = byte_count == 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= 2'd0;
      space_count <= '0;
      line_count  <= '0;
    end else if (accept) begin
      if (end_of_stream) begin
        // flush and start a fresh stream
        byte_count  <= 2'd0;
        space_count <= '0;
        line_count  <= '0;
      end else if (byte_count != 2'd2) begin
        byte_count <= byte_count + 2'd1;
      end else begin
        byte_count  <= 2'd0;
        space_count <= sp_due ? SPC_W'(1) : space_count + SPC_W'(1);
        line_count  <= nl_due ? LNC_W'(1) : line_count + LNC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !end_of_stream && byte_count != 2'd2) begin
      pend[byte_count[0]] <= data_byte;
    end
  end

`ifndef SYNTH
  a_byte_count_range : assert property (@(posedge clk) disable iff (rst)
    byte_count != 2'd3)
    else $error("byte_count out of range");
`endif

endmodule

`default_nettype wire

/* hdl/b64f_queue.sv */
// ----------------------------------------------------------------------------
// b64f_queue
// Two-entry command queue between the group collector and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module b64f_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire b64f_pkg::grp_cmd_t  wr_data,
  input  wire logic                rd_en,
  output b64f_pkg::grp_cmd_t       rd_data,
  output logic                     full,
  output logic                     nonempty
);

  b64f_pkg::grp_cmd_t                mem [b64f_pkg::QUEUE_DEPTH];
  logic [b64f_pkg::QPTR_W-1:0]       wr_ptr;
  logic [b64f_pkg::QPTR_W-1:0]       rd_ptr;
  logic [b64f_pkg::QCNT_W-1:0]       count;

  assign full     = count == b64f_pkg::QCNT_W'(b64f_pkg::QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + b64f_pkg::QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + b64f_pkg::QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + b64f_pkg::QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - b64f_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

`ifndef SYNTH
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("queue written while full");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    rd_en |-> nonempty)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

/* hdl/b64f_back.sv */
// ----------------------------------------------------------------------------
// b64f_back
// Holds the alphabet and turns queued group commands into characters,
// one per cycle through an output register, as long as pop keeps it drained.
// ----------------------------------------------------------------------------
`default_nettype none

module b64f_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [b64f_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [b64f_pkg::KEY_W-1:0]            cfg_data,
  input  wire b64f_pkg::grp_cmd_t                    q_data,
  input  wire logic                                  q_nonempty,
  output logic                                       q_pop,
  input  wire logic                                  pop,
  output logic                                       out_valid,
  output logic [b64f_pkg::CHAR_W-1:0]                enc_char,
  output logic                                       last
);

  typedef enum logic [5:0] {
    ST_SPACE = 6'b000001,
    ST_NL    = 6'b000010,
    ST_C0    = 6'b000100,
    ST_C1    = 6'b001000,
    ST_C2    = 6'b010000,
    ST_C3    = 6'b100000
  } step_t;

  logic [b64f_pkg::KEY_WORDS-1:0][b64f_pkg::KEY_W-1:0] key_word;

  b64f_pkg::grp_cmd_t cmd;
  logic               busy;
  step_t              step;
  step_t              step_next;
  step_t              first_step;

  logic                         advance;
  logic                         fetch;
  logic [b64f_pkg::IDX_W-1:0]   idx;
  logic [b64f_pkg::CHAR_W-1:0]  key_char;
  logic [b64f_pkg::CHAR_W-1:0]  cur_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word <= '0;
    end else if (cfg_we && cfg_index < b64f_pkg::CFG_IDX_W'(b64f_pkg::KEY_WORDS)) begin
      key_word[cfg_index[b64f_pkg::KEY_SEL_W-1:0]] <= cfg_data;
    end
  end

  assign advance = busy && (!out_valid || pop);
  assign fetch   = !busy || (advance && step == ST_C3);
  assign q_pop   = fetch && q_nonempty;

  always_comb begin
    if (q_data.sp) begin
      first_step = ST_SPACE;
    end else if (q_data.nl) begin
      first_step = ST_NL;
    end else begin
      first_step = ST_C0;
    end
  end

  always_comb begin
    idx       = '0;
    cur_char  = b64f_pkg::CHAR_SPACE;
    step_next = ST_C0;
    unique case (step)
      ST_SPACE: begin
        cur_char  = b64f_pkg::CHAR_SPACE;
        step_next = cmd.nl ? ST_NL : ST_C0;
      end
      ST_NL: begin
        cur_char  = b64f_pkg::CHAR_NEWLINE;
        step_next = ST_C0;
      end
      ST_C0: begin
        idx       = cmd.b0[7:2];
        step_next = ST_C1;
      end
      ST_C1: begin
        idx       = {cmd.b0[1:0], cmd.b1[7:4]};
        step_next = ST_C2;
      end
      ST_C2: begin
        idx       = {cmd.b1[3:0], cmd.b2[7:6]};
        step_next = ST_C3;
      end
      ST_C3: begin
        idx       = cmd.b2[5:0];
        step_next = ST_C0;
      end
      default: begin
        step_next = ST_C0;
      end
    endcase

    key_char = key_word[idx[5:3]][{idx[2:0], 3'b000} +: b64f_pkg::CHAR_W];

    unique case (step) inside
      ST_C0, ST_C1: cur_char = key_char;
      ST_C2:        cur_char = (cmd.pad == b64f_pkg::PAD_TWO) ? b64f_pkg::CHAR_PAD : key_char;
      ST_C3:        cur_char = (cmd.pad != b64f_pkg::PAD_NONE) ? b64f_pkg::CHAR_PAD : key_char;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_C0;
    end else if (fetch) begin
      busy <= q_nonempty;
      if (q_nonempty) begin
        step <= first_step;
      end
    end else if (advance) begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch && q_nonempty) begin
      cmd <= q_data;
    end
  end

  // output register: load on advance, drop on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      enc_char <= cur_char;
      last     <= step == ST_C3;
    end
  end

`ifndef SYNTH
  a_fetch_on_group_end : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!busy || (step == ST_C3 && (!out_valid || pop))))
    else $error("new group taken before the current one finished");
`endif

endmodule

`default_nettype wire

/* hdl/base64_encoder_formatted_top.sv */
// ----------------------------------------------------------------------------
// base64_encoder_formatted_top
// Formatted base64 encoder with a programmable 64-character alphabet.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   input    | in        | push / full            | data_byte, end_of_stream
//   result   | out       | pop / empty            | enc_char, last
//   config   | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Input bytes are taken one per cycle while full is low; each group of three
// yields four to six characters, emitted one per cycle while pop keeps up, by
// the single character port of the emitter.
// A two-entry group queue lets the collector keep taking bytes while the
// emitter drains; full rises only when both entries are taken.
// Reset is synchronous and clears counters, queue, output and alphabet.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_encoder_formatted_top #(
  parameter int GROUPS_PER_SPACE = 2,
  parameter int GROUPS_PER_LINE  = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [7:0]                        data_byte,
  input  wire logic                              end_of_stream,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [7:0]                             enc_char,
  output logic                                   last,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [b64f_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [b64f_pkg::KEY_W-1:0]        cfg_data
);

  logic               enq;
  b64f_pkg::grp_cmd_t enq_cmd;
  b64f_pkg::grp_cmd_t q_data;
  logic               q_pop;
  logic               q_full;
  logic               q_nonempty;
  logic               out_valid;

  assign full      = q_full;
  assign empty     = !out_valid;
  assign cfg_ready = 1'b1;

  b64f_front #(
    .GROUPS_PER_SPACE (GROUPS_PER_SPACE),
    .GROUPS_PER_LINE  (GROUPS_PER_LINE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .q_full        (q_full),
    .enq           (enq),
    .enq_cmd       (enq_cmd)
  );

  b64f_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (enq),
    .wr_data  (enq_cmd),
    .rd_en    (q_pop),
    .rd_data  (q_data),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  b64f_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_data     (q_data),
    .q_nonempty (q_nonempty),
    .q_pop      (q_pop),
    .pop        (pop),
    .out_valid  (out_valid),
    .enc_char   (enc_char),
    .last       (last)
  );

endmodule

`default_nettype wire

/* sim/b64f_checker.sv */
// ----------------------------------------------------------------------------
// b64f_checker
// Watches the byte, character and alphabet channels of the formatted base64
// encoder. It keeps its own copy of the alphabet, the partial group and the
// space/newline counters, expands every accepted byte or end marker into the
// characters it must produce, and compares each popped character and its
// last flag against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module b64f_checker #(
  parameter int GROUPS_PER_SPACE = 2,
  parameter int GROUPS_PER_LINE  = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  logic [7:0]                          data_byte,
  input  logic                                end_of_stream,
  input  logic                                empty,
  input  logic                                pop,
  input  logic [7:0]                          enc_char,
  input  logic                                last,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [b64f_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [b64f_pkg::KEY_W-1:0]          cfg_data,
  output int unsigned                         mismatch_count,
  output int unsigned                         chars_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [b64f_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } enc_char_t;

  enc_char_t                   expected_chars[$];
  logic [b64f_pkg::KEY_W-1:0]  alphabet [b64f_pkg::KEY_WORDS];
  logic [7:0]                  held_bytes [2];
  logic [1:0]                  held_cnt;
  int unsigned                 groups_since_space;
  int unsigned                 groups_since_line;

  initial begin
    mismatch_count    = 0;
    chars_outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] encoder mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [b64f_pkg::CHAR_W-1:0] alphabet_char(
      input logic [b64f_pkg::IDX_W-1:0] idx);
    return alphabet[idx[5:3]][8*idx[2:0] +: 8];
  endfunction

  // Expand one group of three bytes into separators plus four characters.
  task automatic encode_group(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input b64f_pkg::pad_t pad);
    logic [b64f_pkg::IDX_W-1:0]  idx [4];
    logic [b64f_pkg::CHAR_W-1:0] ch [4];
    idx[0] = b0[7:2];
    idx[1] = {b0[1:0], b1[7:4]};
    idx[2] = {b1[3:0], b2[7:6]};
    idx[3] = b2[5:0];
    for (int i = 0; i < 4; i++) ch[i] = alphabet_char(idx[i]);
    if (pad != b64f_pkg::PAD_NONE) ch[3] = b64f_pkg::CHAR_PAD;
    if (pad == b64f_pkg::PAD_TWO) ch[2] = b64f_pkg::CHAR_PAD;
    // space goes out ahead of the newline
    if (groups_since_space >= GROUPS_PER_SPACE) begin
      expected_chars.push_back('{ch: b64f_pkg::CHAR_SPACE, last: 1'b0});
      groups_since_space = 0;
    end
    if (groups_since_line >= GROUPS_PER_LINE) begin
      expected_chars.push_back('{ch: b64f_pkg::CHAR_NEWLINE, last: 1'b0});
      groups_since_line = 0;
    end
    for (int i = 0; i < 4; i++)
      expected_chars.push_back('{ch: ch[i], last: (i == 3)});
    groups_since_space++;
    groups_since_line++;
  endtask

  task automatic predict_input(input logic [7:0] b, input logic eos);
    if (eos) begin
      if (held_cnt == 2'd1)
        encode_group(held_bytes[0], 8'h00, 8'h00, b64f_pkg::PAD_TWO);
      else if (held_cnt >= 2'd2)
        encode_group(held_bytes[0], held_bytes[1], 8'h00, b64f_pkg::PAD_ONE);
      held_cnt           = 2'd0;
      groups_since_space = 0;
      groups_since_line  = 0;
    end else if (held_cnt < 2'd2) begin
      held_bytes[held_cnt[0]] = b;
      held_cnt++;
    end else begin
      encode_group(held_bytes[0], held_bytes[1], b, b64f_pkg::PAD_NONE);
      held_cnt = 2'd0;
    end
  endtask

  task automatic check_char(input logic [7:0] ch, input logic lst);
    enc_char_t exp_char;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ch, lst));
    end else begin
      exp_char = expected_chars.pop_front();
      if (ch !== exp_char.ch)
        report_mismatch($sformatf("enc_char 0x%02h, expected 0x%02h", ch, exp_char.ch));
      if (lst !== exp_char.last)
        report_mismatch($sformatf("last %0b on char 0x%02h, expected %0b",
                                  lst, ch, exp_char.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_chars.delete();
      for (int w = 0; w < b64f_pkg::KEY_WORDS; w++) alphabet[w] = '0;
      held_bytes[0]      = 8'h00;
      held_bytes[1]      = 8'h00;
      held_cnt           = 2'd0;
      groups_since_space = 0;
      groups_since_line  = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < b64f_pkg::KEY_WORDS)
        alphabet[cfg_index[b64f_pkg::KEY_SEL_W-1:0]] = cfg_data;
      if (pop && !empty) check_char(enc_char, last);
      if (push && !full) predict_input(data_byte, end_of_stream);
    end
    chars_outstanding <= expected_chars.size();
  end

endmodule

/* sim/base64_encoder_formatted_top_tb.sv */
// ----------------------------------------------------------------------------
// base64_encoder_formatted_top_tb
// Drives byte streams and alphabet writes into the formatted base64 encoder.
// A directed pass covers empty flushes, one- and two-byte tails and extreme
// byte values; random streams of varied length follow under several
// alphabets, with random idle cycles on both sides, a stretch without idling,
// a long character hold-off that backs up the input, and drains between
// phases. Checking is done by b64f_checker.
// ----------------------------------------------------------------------------
module base64_encoder_formatted_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GROUPS_PER_SPACE = 2;
  localparam int GROUPS_PER_LINE  = 12;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int HOLD_CYCLES      = 80;
  localparam int IDLE_PERCENT     = 10;

  localparam logic [b64f_pkg::CFG_IDX_W-1:0] KEY_WORD_0   = 4'd0;
  localparam logic [b64f_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd9;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            push          = 1'b0;
  logic                            full;
  logic [7:0]                      data_byte     = 8'h00;
  logic                            end_of_stream = 1'b0;
  logic                            empty;
  logic                            pop           = 1'b0;
  logic [7:0]                      enc_char;
  logic                            last;
  logic                            cfg_valid     = 1'b0;
  logic                            cfg_ready;
  logic [b64f_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [b64f_pkg::KEY_W-1:0]      cfg_data      = '0;
  int unsigned                     mismatch_count;
  int unsigned                     chars_outstanding;

  logic                            no_idle       = 1'b0;
  logic                            sink_hold_req = 1'b0;
  int unsigned                     cycle_count   = 0;
  logic [b64f_pkg::KEY_W-1:0]      key_image [b64f_pkg::KEY_WORDS];

  base64_encoder_formatted_top #(
    .GROUPS_PER_SPACE (GROUPS_PER_SPACE),
    .GROUPS_PER_LINE  (GROUPS_PER_LINE)
  ) dut (.*);

  b64f_checker #(
    .GROUPS_PER_SPACE (GROUPS_PER_SPACE),
    .GROUPS_PER_LINE  (GROUPS_PER_LINE)
  ) encode_chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("== FAIL ==");
    $finish;
  end

  // Character sink: random idling, plus one long hold-off when requested.
  initial begin
    int  hold_left;
    bit  hold_armed;
    hold_left  = 0;
    hold_armed = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (sink_hold_req && !hold_armed) begin
        hold_armed = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        if (!sink_hold_req) hold_armed = 1'b0;
        pop <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  function automatic logic [b64f_pkg::KEY_W-1:0] std_key_word(input int w);
    logic [b64f_pkg::KEY_W-1:0] word;
    logic [7:0]                 ch;
    int                         c;
    word = '0;
    for (int j = 0; j < 8; j++) begin
      c = w * 8 + j;
      if (c < 26)      ch = "A" + 8'(c);
      else if (c < 52) ch = "a" + 8'(c - 26);
      else if (c < 62) ch = "0" + 8'(c - 52);
      else if (c == 62) ch = "+";
      else             ch = "/";
      word[8*j +: 8] = ch;
    end
    return word;
  endfunction

  // Offer one item; return at the edge where it is taken. Push stays high.
  task automatic send_item(input logic [7:0] b, input logic eos);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (full);
  endtask

  task automatic send_stream(input int n_bytes);
    for (int i = 0; i < n_bytes; i++) send_item(8'($urandom), 1'b0);
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic run_streams(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      // mostly short streams, now and then one long enough for a newline
      if ($urandom_range(3) == 0) len = $urandom_range(39, 45);
      else                        len = $urandom_range(0, 10);
      send_stream(len);
      sent += len + 1;
    end
  endtask

  // Hold input until every character is out, then let the block settle.
  task automatic drain_outputs();
    push <= 1'b0;
    do @(posedge clk); while (chars_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_alphabet(input bit add_unmapped);
    for (int w = 0; w < b64f_pkg::KEY_WORDS; w++) begin
      cfg_valid <= 1'b1;
      cfg_index <= KEY_WORD_0 + w[b64f_pkg::CFG_IDX_W-1:0];
      cfg_data  <= key_image[w];
      do @(posedge clk); while (!cfg_ready);
    end
    if (add_unmapped) begin
      cfg_index <= CFG_UNMAPPED;
      cfg_data  <= {$urandom, $urandom};
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Standard alphabet, directed items
    for (int w = 0; w < b64f_pkg::KEY_WORDS; w++) key_image[w] = std_key_word(w);
    program_alphabet(1'b0);
    send_item(8'hFF, 1'b1);                    // flush with nothing held
    send_item(8'h00, 1'b0); send_item(8'h00, 1'b0); send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0); send_item(8'hFF, 1'b0); send_item(8'hFF, 1'b0);
    send_item(8'h4D, 1'b0); send_item(8'h61, 1'b0); send_item(8'h6E, 1'b0);
    send_item(8'hA5, 1'b0); send_item(8'h5A, 1'b0); send_item(8'hC3, 1'b0);
    send_item(8'hFF, 1'b0); send_item(8'hAA, 1'b1);  // one-byte tail
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b0); send_item(8'hFF, 1'b0); send_item(8'h55, 1'b1);
    send_item(8'h81, 1'b1);
    drain_outputs();

    // All-ones alphabet
    for (int w = 0; w < b64f_pkg::KEY_WORDS; w++) key_image[w] = '1;
    program_alphabet(1'b0);
    run_streams(3);
    drain_outputs();

    // All-zero alphabet; a write past the last key word must be ignored
    for (int w = 0; w < b64f_pkg::KEY_WORDS; w++) key_image[w] = '0;
    program_alphabet(1'b1);
    run_streams(3);
    drain_outputs();

    // Random alphabet with back-pressure
    for (int w = 0; w < b64f_pkg::KEY_WORDS; w++) key_image[w] = {$urandom, $urandom};
    program_alphabet(1'b0);
    run_streams(3);
    no_idle <= 1'b1;
    run_streams(12);
    no_idle <= 1'b0;
    sink_hold_req <= 1'b1;
    send_stream(30);
    sink_hold_req <= 1'b0;
    drain_outputs();

    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
